// File: rtl/cra_pkg.sv
// cra_pkg: types and codes shared by the contiguous region allocator
// used by cra_checker, tb and contiguous_region_allocator
// no dependencies
package cra_pkg;

   localparam int SIZE_W  = 21;
   localparam int OWNER_W = 8;
   localparam int ADDR_W  = 20;

   localparam logic [SIZE_W-1:0] MEM_MAX = 21'd1048576;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_COMPACT = 2'd2;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_NOID  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [OWNER_W-1:0] proc_id;
      logic [SIZE_W-1:0]  alloc_size;
      logic [1:0]         fit_mode;
   } cra_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] base_address;
   } cra_rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  size;
      logic [OWNER_W-1:0] owner;
   } cra_entry_type;

endpackage

// File: rtl/cra_ram.sv
// cra_ram: generic single write, single read ram with registered read
// no dependencies
module cra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/contiguous_region_allocator.sv
// contiguous_region_allocator: ordered region table with allocate, release, compact
// depends on cra_pkg and cra_ram
//
//   port group   dir   beat / use
//   req_*        in    one command: cmd, proc_id, alloc_size, fit_mode
//   rsp_*        out   one result: status, base_address
//   csr_*        in    memory_size write, rebuilds the table
//
// each valid alloc, release or compact walks the region table through the single ram port pair,
// with a read state and an evaluate or write state for each entry visited,
// both for a scan over N entries and for a shift of M entries
// after reset or a memory_size write, S_INIT rebuilds entry 0 before req_stall drops
// a finished result waits in the output register; the next command is taken
// meanwhile and holds at the end until rsp_stall lets the old beat go
module contiguous_region_allocator
   import cra_pkg::*;
#(
   parameter int MAX_REGIONS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cra_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cra_rsp_type       rsp_data,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_REGIONS);
   localparam int K_W   = $clog2(MAX_REGIONS + 2);
   localparam logic [K_W-1:0] K_ONE = K_W'(1);
   localparam logic [K_W-1:0] K_MAX = K_W'(MAX_REGIONS);

   localparam logic [4:0] S_INIT   = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_FIN    = 5'd2;
   localparam logic [4:0] S_AS_RD  = 5'd3;
   localparam logic [4:0] S_AS_EV  = 5'd4;
   localparam logic [4:0] S_AS_DEC = 5'd5;
   localparam logic [4:0] S_IN_RD  = 5'd6;
   localparam logic [4:0] S_IN_WR  = 5'd7;
   localparam logic [4:0] S_IN_FIX = 5'd8;
   localparam logic [4:0] S_IN_OWN = 5'd9;
   localparam logic [4:0] S_RS_RD  = 5'd10;
   localparam logic [4:0] S_RS_EV  = 5'd11;
   localparam logic [4:0] S_RN_EV  = 5'd12;
   localparam logic [4:0] S_RL_DEC = 5'd13;
   localparam logic [4:0] S_RM_RD  = 5'd14;
   localparam logic [4:0] S_RM_WR  = 5'd15;
   localparam logic [4:0] S_CP_RD  = 5'd16;
   localparam logic [4:0] S_CP_EV  = 5'd17;
   localparam logic [4:0] S_CP_END = 5'd18;

   logic [4:0]        state_ff, state_in;
   logic [SIZE_W-1:0] mem_size_ff, mem_size_in;
   logic [K_W-1:0]    count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cra_rsp_type       rsp_data_ff, rsp_data_in;

   cra_req_type       cur_ff, cur_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [K_W-1:0]    pick_ff, pick_in;
   logic [K_W-1:0]    used_ff, used_in;
   logic [1:0]        shift_d_ff, shift_d_in;
   logic              found_ff, found_in;
   logic [SIZE_W-1:0] pick_size_ff, pick_size_in;
   logic [SIZE_W-1:0] pick_base_ff, pick_base_in;
   logic [SIZE_W-1:0] base_acc_ff, base_acc_in;
   logic [SIZE_W-1:0] spare_ff, spare_in;
   logic              prev_free_ff, prev_free_in;
   logic [SIZE_W-1:0] prev_size_ff, prev_size_in;
   logic              next_free_ff, next_free_in;
   logic [SIZE_W-1:0] next_size_ff, next_size_in;
   logic [SIZE_W-1:0] cur_size_ff, cur_size_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [SIZE_W-1:0] res_base_ff, res_base_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   cra_entry_type     wr_data;
   logic [IDX_W-1:0]  rd_addr;
   cra_entry_type     rd_data;

   logic              fits;
   logic              better;
   logic [SIZE_W-1:0] merge_sum;
   logic [SIZE_W-1:0] cfg_value;

   cra_ram #(
      .WIDTH ($bits(cra_entry_type)),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign fits   = (rd_data.owner == '0) && (rd_data.size >= cur_ff.alloc_size);
   assign better = !found_ff
                   || ((cur_ff.fit_mode == FIT_BEST) && (rd_data.size < pick_size_ff))
                   || ((cur_ff.fit_mode == FIT_WORST) && (rd_data.size > pick_size_ff));
   assign merge_sum = cur_size_ff + (prev_free_ff ? prev_size_ff : '0)
                      + (next_free_ff ? next_size_ff : '0);

   always_comb begin
      cfg_value = csr_wr_data;
      if (csr_wr_data == '0) begin
         cfg_value = SIZE_W'(1);
      end else if (csr_wr_data > MEM_MAX) begin
         cfg_value = MEM_MAX;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mem_size_in   = mem_size_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      pick_in       = pick_ff;
      used_in       = used_ff;
      shift_d_in    = shift_d_ff;
      found_in      = found_ff;
      pick_size_in  = pick_size_ff;
      pick_base_in  = pick_base_ff;
      base_acc_in   = base_acc_ff;
      spare_in      = spare_ff;
      prev_free_in  = prev_free_ff;
      prev_size_in  = prev_size_ff;
      next_free_in  = next_free_ff;
      next_size_in  = next_size_ff;
      cur_size_in   = cur_size_ff;
      res_status_in = res_status_ff;
      res_base_in   = res_base_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = k_ff[IDX_W-1:0];

      case (state_ff)
         S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{size: mem_size_ff, owner: '0};
            count_in = K_ONE;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cur_in        = req_data;
               k_in          = '0;
               base_acc_in   = '0;
               found_in      = 1'b0;
               prev_free_in  = 1'b0;
               used_in       = '0;
               spare_in      = '0;
               res_status_in = ST_OK;
               res_base_in   = '0;
               case (req_data.cmd)
                  CMD_ALLOC: begin
                     if (req_data.proc_id == '0) begin
                        res_status_in = ST_NOID;
                        state_in      = S_FIN;
                     end else if ((req_data.alloc_size == '0)
                                  || ((req_data.fit_mode != FIT_FIRST)
                                      && (req_data.fit_mode != FIT_BEST)
                                      && (req_data.fit_mode != FIT_WORST))) begin
                        res_status_in = ST_NOFIT;
                        state_in      = S_FIN;
                     end else begin
                        state_in = S_AS_RD;
                     end
                  end
                  CMD_RELEASE: begin
                     if (req_data.proc_id == '0) begin
                        res_status_in = ST_NOID;
                        state_in      = S_FIN;
                     end else begin
                        state_in = S_RS_RD;
                     end
                  end
                  CMD_COMPACT: begin
                     state_in = S_CP_RD;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = res_status_ff;
               rsp_data_in.base_address = res_base_ff[ADDR_W-1:0];
               state_in                 = S_IDLE;
            end
         end
         S_AS_RD: begin
            state_in = S_AS_EV;
         end
         S_AS_EV: begin
            if (fits && better) begin
               pick_in      = k_ff;
               pick_size_in = rd_data.size;
               pick_base_in = base_acc_ff;
               found_in     = 1'b1;
            end
            base_acc_in = base_acc_ff + rd_data.size;
            k_in        = k_ff + K_ONE;
            if (((cur_ff.fit_mode == FIT_FIRST) && fits) || (k_ff + K_ONE >= count_ff)) begin
               state_in = S_AS_DEC;
            end else begin
               state_in = S_AS_RD;
            end
         end
         S_AS_DEC: begin
            if (!found_ff) begin
               res_status_in = ST_NOFIT;
               state_in      = S_FIN;
            end else if (pick_size_ff == cur_ff.alloc_size) begin
               wr_en         = 1'b1;
               wr_addr       = pick_ff[IDX_W-1:0];
               wr_data       = '{size: pick_size_ff, owner: cur_ff.proc_id};
               res_status_in = ST_OK;
               res_base_in   = pick_base_ff;
               state_in      = S_FIN;
            end else if (count_ff >= K_MAX) begin
               res_status_in = ST_FULL;
               state_in      = S_FIN;
            end else if (pick_ff + K_ONE == count_ff) begin
               state_in = S_IN_FIX;
            end else begin
               k_in     = count_ff - K_ONE;
               state_in = S_IN_RD;
            end
         end
         S_IN_RD: begin
            state_in = S_IN_WR;
         end
         S_IN_WR: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(k_ff + K_ONE);
            wr_data = rd_data;
            if (k_ff == pick_ff + K_ONE) begin
               state_in = S_IN_FIX;
            end else begin
               k_in     = k_ff - K_ONE;
               state_in = S_IN_RD;
            end
         end
         S_IN_FIX: begin
            wr_en    = 1'b1;
            wr_addr  = IDX_W'(pick_ff + K_ONE);
            wr_data  = '{size: pick_size_ff - cur_ff.alloc_size, owner: '0};
            state_in = S_IN_OWN;
         end
         S_IN_OWN: begin
            wr_en         = 1'b1;
            wr_addr       = pick_ff[IDX_W-1:0];
            wr_data       = '{size: cur_ff.alloc_size, owner: cur_ff.proc_id};
            count_in      = count_ff + K_ONE;
            res_status_in = ST_OK;
            res_base_in   = pick_base_ff;
            state_in      = S_FIN;
         end
         S_RS_RD: begin
            state_in = S_RS_EV;
         end
         S_RS_EV: begin
            rd_addr = IDX_W'(k_ff + K_ONE);
            if (rd_data.owner == cur_ff.proc_id) begin
               pick_in      = k_ff;
               cur_size_in  = rd_data.size;
               pick_base_in = base_acc_ff;
               if (k_ff + K_ONE < count_ff) begin
                  state_in = S_RN_EV;
               end else begin
                  next_free_in = 1'b0;
                  state_in     = S_RL_DEC;
               end
            end else begin
               prev_free_in = (rd_data.owner == '0);
               prev_size_in = rd_data.size;
               base_acc_in  = base_acc_ff + rd_data.size;
               if (k_ff + K_ONE < count_ff) begin
                  k_in     = k_ff + K_ONE;
                  state_in = S_RS_RD;
               end else begin
                  res_status_in = ST_NOID;
                  state_in      = S_FIN;
               end
            end
         end
         S_RN_EV: begin
            next_free_in = (rd_data.owner == '0);
            next_size_in = rd_data.size;
            state_in     = S_RL_DEC;
         end
         S_RL_DEC: begin
            wr_en   = 1'b1;
            wr_data = '{size: merge_sum, owner: '0};
            if (prev_free_ff) begin
               wr_addr = IDX_W'(pick_ff - K_ONE);
            end else begin
               wr_addr = pick_ff[IDX_W-1:0];
            end
            res_status_in = ST_OK;
            res_base_in   = pick_base_ff;
            shift_d_in    = {1'b0, prev_free_ff} + {1'b0, next_free_ff};
            k_in          = pick_ff + K_ONE + K_W'(next_free_ff);
            if (!prev_free_ff && !next_free_ff) begin
               state_in = S_FIN;
            end else begin
               state_in = S_RM_RD;
            end
         end
         S_RM_RD: begin
            if (k_ff < count_ff) begin
               state_in = S_RM_WR;
            end else begin
               count_in = count_ff - K_W'(shift_d_ff);
               state_in = S_FIN;
            end
         end
         S_RM_WR: begin
            wr_en    = 1'b1;
            wr_addr  = IDX_W'(k_ff - K_W'(shift_d_ff));
            wr_data  = rd_data;
            k_in     = k_ff + K_ONE;
            state_in = S_RM_RD;
         end
         S_CP_RD: begin
            if (k_ff < count_ff) begin
               state_in = S_CP_EV;
            end else begin
               state_in = S_CP_END;
            end
         end
         S_CP_EV: begin
            if (rd_data.owner != '0) begin
               wr_en   = 1'b1;
               wr_addr = used_ff[IDX_W-1:0];
               wr_data = rd_data;
               used_in = used_ff + K_ONE;
            end else begin
               spare_in = spare_ff + rd_data.size;
            end
            k_in     = k_ff + K_ONE;
            state_in = S_CP_RD;
         end
         S_CP_END: begin
            if ((spare_ff != '0) && (used_ff < K_MAX)) begin
               wr_en    = 1'b1;
               wr_addr  = used_ff[IDX_W-1:0];
               wr_data  = '{size: spare_ff, owner: '0};
               count_in = used_ff + K_ONE;
            end else begin
               count_in = used_ff;
            end
            res_status_in = ST_OK;
            res_base_in   = '0;
            state_in      = S_FIN;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      if (csr_wr_en) begin
         mem_size_in = cfg_value;
         state_in    = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         mem_size_ff  <= MEM_MAX;
         count_ff     <= K_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mem_size_ff  <= mem_size_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      pick_ff       <= pick_in;
      used_ff       <= used_in;
      shift_d_ff    <= shift_d_in;
      found_ff      <= found_in;
      pick_size_ff  <= pick_size_in;
      pick_base_ff  <= pick_base_in;
      base_acc_ff   <= base_acc_in;
      spare_ff      <= spare_in;
      prev_free_ff  <= prev_free_in;
      prev_size_ff  <= prev_size_in;
      next_free_ff  <= next_free_in;
      next_size_ff  <= next_size_in;
      cur_size_ff   <= cur_size_in;
      res_status_ff <= res_status_in;
      res_base_ff   <= res_base_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= K_MAX))
      else $error("region count out of range");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("table written while idle");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && rsp_valid_ff && rsp_stall && !csr_wr_en |=> (state_ff == S_FIN))
      else $error("result lost while output beat stalled");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result beat changed");
`endif

endmodule

// File: test/cra_checker.sv
// cra_checker: watches the command and result channels of the region allocator,
// keeps its own region table and compares every result beat in order
// depends on cra_pkg
module cra_checker
   import cra_pkg::*;
#(
   parameter int MAX_REGIONS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  cra_req_type       req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  cra_rsp_type       rsp_data,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [SIZE_W-1:0]  tbl_size[MAX_REGIONS];
   logic [OWNER_W-1:0] tbl_owner[MAX_REGIONS];
   int                 tbl_count;
   logic [SIZE_W-1:0]  mem_units;
   cra_rsp_type        expected_rsps[$];

   function automatic void rebuild_table();
      for (int k = 0; k < MAX_REGIONS; k++) begin
         tbl_size[k] = '0;
         tbl_owner[k] = '0;
      end
      tbl_size[0] = mem_units;
      tbl_count = 1;
   endfunction

   function automatic int unsigned start_of(int idx);
      int unsigned sum;
      sum = 0;
      for (int k = 0; k < idx; k++) sum += tbl_size[k];
      return sum;
   endfunction

   function automatic void drop_entry(int idx);
      for (int k = idx; k + 1 < tbl_count; k++) begin
         tbl_size[k] = tbl_size[k+1];
         tbl_owner[k] = tbl_owner[k+1];
      end
      tbl_count--;
      tbl_size[tbl_count] = '0;
      tbl_owner[tbl_count] = '0;
   endfunction

   function automatic cra_rsp_type place_region(cra_req_type r);
      cra_rsp_type res;
      int pick;
      bit found;
      res = '0;
      pick = 0;
      found = 0;
      if (r.proc_id == 0) begin
         res.status = ST_NOID;
         return res;
      end
      if (r.alloc_size == 0 || !(r.fit_mode inside {FIT_FIRST, FIT_BEST, FIT_WORST})) begin
         res.status = ST_NOFIT;
         return res;
      end
      for (int k = 0; k < tbl_count; k++) begin
         if (tbl_owner[k] != 0 || tbl_size[k] < r.alloc_size) continue;
         if (!found) begin
            pick = k;
            found = 1;
            if (r.fit_mode == FIT_FIRST) break;
         end else if (r.fit_mode == FIT_BEST && tbl_size[k] < tbl_size[pick]) begin
            pick = k;
         end else if (r.fit_mode == FIT_WORST && tbl_size[k] > tbl_size[pick]) begin
            pick = k;
         end
      end
      if (!found) begin
         res.status = ST_NOFIT;
         return res;
      end
      if (tbl_size[pick] > r.alloc_size) begin
         if (tbl_count >= MAX_REGIONS) begin
            res.status = ST_FULL;
            return res;
         end
         for (int k = tbl_count; k > pick + 1; k--) begin
            tbl_size[k] = tbl_size[k-1];
            tbl_owner[k] = tbl_owner[k-1];
         end
         tbl_size[pick+1] = tbl_size[pick] - r.alloc_size;
         tbl_owner[pick+1] = '0;
         tbl_size[pick] = r.alloc_size;
         tbl_count++;
      end
      tbl_owner[pick] = r.proc_id;
      res.status = ST_OK;
      res.base_address = ADDR_W'(start_of(pick));
      return res;
   endfunction

   function automatic cra_rsp_type free_region(logic [OWNER_W-1:0] id);
      cra_rsp_type res;
      int p;
      res = '0;
      res.status = ST_NOID;
      if (id == 0) return res;
      for (int q = 0; q < tbl_count; q++) begin
         if (tbl_owner[q] != id) continue;
         p = q;
         res.status = ST_OK;
         res.base_address = ADDR_W'(start_of(p));
         tbl_owner[p] = '0;
         if (p > 0 && tbl_owner[p-1] == 0) begin
            tbl_size[p-1] += tbl_size[p];
            drop_entry(p);
            p--;
         end
         if (p + 1 < tbl_count && tbl_owner[p+1] == 0) begin
            tbl_size[p] += tbl_size[p+1];
            drop_entry(p + 1);
         end
         return res;
      end
      return res;
   endfunction

   function automatic void squeeze_table();
      int used;
      int unsigned spare;
      used = 0;
      spare = 0;
      for (int k = 0; k < tbl_count; k++) begin
         if (tbl_owner[k] != 0) begin
            tbl_size[used] = tbl_size[k];
            tbl_owner[used] = tbl_owner[k];
            used++;
         end else begin
            spare += tbl_size[k];
         end
      end
      if (spare > 0 && used < MAX_REGIONS) begin
         tbl_size[used] = SIZE_W'(spare);
         tbl_owner[used] = '0;
         used++;
      end
      for (int k = used; k < MAX_REGIONS; k++) begin
         tbl_size[k] = '0;
         tbl_owner[k] = '0;
      end
      tbl_count = used;
   endfunction

   function automatic cra_rsp_type predict_command(cra_req_type r);
      cra_rsp_type res;
      res = '0;
      case (r.cmd)
         CMD_ALLOC: res = place_region(r);
         CMD_RELEASE: res = free_region(r.proc_id);
         CMD_COMPACT: squeeze_table();
         default: ;
      endcase
      if (res.status != ST_OK) res.base_address = '0;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      cra_rsp_type want;
      if (reset) begin
         mem_units = MEM_MAX;
         rebuild_table();
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_wr_data == 0) mem_units = SIZE_W'(1);
            else if (csr_wr_data > MEM_MAX) mem_units = MEM_MAX;
            else mem_units = csr_wr_data;
            rebuild_table();
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.base_address !== want.base_address)
                  report_mismatch("base_address", rsp_data.base_address, want.base_address);
            end
         end
         if (req_valid && !req_stall) expected_rsps.push_back(predict_command(req_data));
      end
   end
endmodule

// File: test/tb.sv
// tb: stimulus and verdict for contiguous_region_allocator
// depends on cra_pkg, cra_checker and the allocator rtl
module tb;
   import cra_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGIONS = 64;
   localparam int CYCLE_LIMIT = 1500000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   cra_req_type       req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   cra_rsp_type       rsp_data;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;
   int                fail_count;
   int                pending_count;
   int                cycle_count;
   int                burst_left;
   int                stall_mode;

   contiguous_region_allocator #(.MAX_REGIONS(NUM_REGIONS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   cra_checker #(.MAX_REGIONS(NUM_REGIONS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern: free, light, heavy, periodic
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= cycle_count[3];
      endcase
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic send_beat(cra_req_type r);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   task automatic send_cmd(logic [1:0] c, logic [OWNER_W-1:0] id, logic [SIZE_W-1:0] sz,
                           logic [1:0] fm);
      cra_req_type r;
      r.cmd = c;
      r.proc_id = id;
      r.alloc_size = sz;
      r.fit_mode = fm;
      send_beat(r);
   endtask

   task automatic drain_results();
      if (burst_left != 0) req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4 * NUM_REGIONS + 20) @(posedge clock);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] v);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // mostly small allocations from a small id pool so releases find owners
   task automatic random_cmd(int unsigned span);
      logic [SIZE_W-1:0] sz;
      logic [1:0] c;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) c = CMD_ALLOC;
      else if (pick < 88) c = CMD_RELEASE;
      else if (pick < 95) c = CMD_COMPACT;
      else c = 2'd3;
      if ($urandom_range(0, 19) == 0) sz = SIZE_W'($urandom);
      else sz = SIZE_W'($urandom_range(1, span));
      send_cmd(c, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)),
               sz, ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cycle_count = 0;
      burst_left = 0;
      stall_mode = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each fit, id zero, unknown codes, duplicates
      send_cmd(CMD_ALLOC, 8'd1, 21'd100, FIT_FIRST);
      send_cmd(CMD_ALLOC, 8'd2, 21'd50, FIT_BEST);
      send_cmd(CMD_ALLOC, 8'd3, 21'd200, FIT_WORST);
      send_cmd(CMD_ALLOC, 8'd255, 21'd10, FIT_FIRST);
      send_cmd(CMD_ALLOC, 8'd1, 21'd7, FIT_FIRST);
      send_cmd(CMD_RELEASE, 8'd2, 21'h1FFFFF, 2'd3);
      send_cmd(CMD_ALLOC, 8'd4, 21'd20, FIT_BEST);
      send_cmd(CMD_ALLOC, 8'd5, 21'd30, FIT_WORST);
      send_cmd(CMD_ALLOC, 8'd6, 21'd30, FIT_BEST);
      send_cmd(CMD_ALLOC, 8'd0, 21'd5, FIT_FIRST);
      send_cmd(CMD_RELEASE, 8'd0, 21'd0, FIT_FIRST);
      send_cmd(CMD_RELEASE, 8'd99, 21'd0, FIT_FIRST);
      send_cmd(CMD_ALLOC, 8'd7, 21'd0, FIT_FIRST);
      send_cmd(CMD_ALLOC, 8'd7, 21'd5, 2'd3);
      send_cmd(CMD_ALLOC, 8'd7, 21'h1FFFFF, FIT_WORST);
      send_cmd(CMD_RELEASE, 8'd1, 21'd0, FIT_FIRST);
      send_cmd(CMD_RELEASE, 8'd255, 21'd0, FIT_FIRST);
      send_cmd(CMD_COMPACT, 8'hAA, 21'h155555, FIT_BEST);
      send_cmd(2'd3, 8'h55, 21'h0AAAAA, FIT_FIRST);
      send_cmd(CMD_ALLOC, 8'd8, 21'd1048576, FIT_FIRST);

      // tiny memory with full table, then exact fit while full
      write_size(21'd64);
      for (int k = 0; k < NUM_REGIONS; k++) send_cmd(CMD_ALLOC, 8'(k + 1), 21'd1, FIT_FIRST);
      send_cmd(CMD_RELEASE, 8'd10, 21'd0, FIT_FIRST);
      send_cmd(CMD_ALLOC, 8'd77, 21'd1, FIT_BEST);
      write_size(21'd100);
      for (int k = 0; k < NUM_REGIONS - 1; k++) send_cmd(CMD_ALLOC, 8'd9, 21'd1, FIT_FIRST);
      send_cmd(CMD_ALLOC, 8'd9, 21'd2, FIT_FIRST);
      send_cmd(CMD_ALLOC, 8'd9, 21'd37, FIT_WORST);

      write_size(21'd0);
      send_cmd(CMD_ALLOC, 8'd1, 21'd1, FIT_FIRST);
      send_cmd(CMD_ALLOC, 8'd2, 21'd1, FIT_FIRST);
      write_size(21'h1FFFFF);

      // random phases over several memory sizes
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: write_size(21'd1000);
            2: write_size(21'd1);
            3: write_size(21'd1048576);
            4: write_size(21'($urandom_range(200, 5000)));
            default: ;
         endcase
         for (int i = 0; i < 70; i++) begin
            random_cmd((ph == 3) ? 70000 : 300);
            if (ph == 2 && i == 50) drain_results();
         end
      end

      drain_results();
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/cra_pkg.sv
rtl/cra_ram.sv
rtl/contiguous_region_allocator.sv
test/cra_checker.sv
test/tb.sv
